>>> hdl/adsr_pkg.sv
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types, register codes and constants for the ADSR envelope gain block.
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COUNT_BITS_DEF  = 16;

    localparam int GAIN_BITS      = 24;
    localparam int GAIN_SHIFT     = 23;
    localparam int STEP_BITS      = 25;
    localparam int LEN_BITS       = 16;
    localparam int PHASE_BITS     = 3;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 25;

    // unity gain, 1.0 in Q1.23
    localparam logic [GAIN_BITS-1:0] GAIN_ONE = 24'h80_0000;

    typedef enum logic [PHASE_BITS-1:0] {
        PH_SILENT  = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ENABLE          = 3'd0,
        REG_ATTACK_SAMPLES  = 3'd1,
        REG_DECAY_SAMPLES   = 3'd2,
        REG_SUSTAIN_SAMPLES = 3'd3,
        REG_RELEASE_SAMPLES = 3'd4,
        REG_ATTACK_STEP     = 3'd5,
        REG_DECAY_STEP      = 3'd6,
        REG_RELEASE_STEP    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic                        enable;
        logic [LEN_BITS-1:0]         attack_samples;
        logic [LEN_BITS-1:0]         decay_samples;
        logic [LEN_BITS-1:0]         sustain_samples;
        logic [LEN_BITS-1:0]         release_samples;
        logic signed [STEP_BITS-1:0] attack_step;
        logic signed [STEP_BITS-1:0] decay_step;
        logic signed [STEP_BITS-1:0] release_step;
    } adsr_cfg_t;

    // gain applied to the current item and the phase after its step
    typedef struct packed {
        logic [GAIN_BITS-1:0] gain;
        phase_t               phase;
    } env_result_t;

endpackage

>>> hdl/adsr_env_state.sv
// ----------------------------------------------------------------------------
// adsr_env_state
// Envelope phase sequencer, position counter and clamped gain accumulator.
// ----------------------------------------------------------------------------
module adsr_env_state
    import adsr_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  adsr_cfg_t   cfg,
    input  logic        advance,
    input  logic        key,
    output env_result_t result
);

    localparam int CMP_BITS = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;
    localparam int SUM_BITS = GAIN_BITS + 2;
    localparam logic [COUNT_BITS-1:0] POS_MAX = '1;

    phase_t                  phase_reg, phase_next, phase_cur;
    logic [COUNT_BITS-1:0]   pos_reg, pos_next, pos_cur, pos_inc;
    logic [GAIN_BITS-1:0]    gain_reg, gain_next, gain_used;
    logic                    key_was_reg, key_was_next;
    logic                    start;
    logic signed [STEP_BITS-1:0] step;
    logic [LEN_BITS-1:0]     len;
    logic signed [SUM_BITS-1:0]  sum;
    logic                    done;

    // attack starts on a rising key edge only from silence
    assign start     = key && !key_was_reg && (phase_reg == PH_SILENT);
    assign phase_cur = start ? PH_ATTACK : phase_reg;
    assign pos_cur   = start ? '0 : pos_reg;

    // per-phase step and length
    always_comb
    begin
        step = '0;
        len  = '0;
        case (phase_cur)
            PH_ATTACK:
            begin
                step = cfg.attack_step;
                len  = cfg.attack_samples;
            end
            PH_DECAY:
            begin
                step = cfg.decay_step;
                len  = cfg.decay_samples;
            end
            PH_SUSTAIN:
            begin
                len  = cfg.sustain_samples;
            end
            PH_RELEASE:
            begin
                step = cfg.release_step;
                len  = cfg.release_samples;
            end
            default:
            begin
                step = '0;
                len  = '0;
            end
        endcase
    end

    assign sum     = $signed({2'b00, gain_reg}) + SUM_BITS'(step);
    assign pos_inc = (pos_cur == POS_MAX) ? pos_cur : pos_cur + 1'b1;
    assign done    = (CMP_BITS'(pos_inc) >= CMP_BITS'(len))
                     && !((phase_cur == PH_SUSTAIN) && key);

    // clamped gain, zero while silent
    always_comb
    begin
        if (phase_cur == PH_SILENT)
            gain_used = '0;
        else if (sum < 0)
            gain_used = '0;
        else if (sum > $signed(SUM_BITS'(GAIN_ONE)))
            gain_used = GAIN_ONE;
        else
            gain_used = sum[GAIN_BITS-1:0];
    end

    // next phase
    always_comb
    begin
        phase_next = phase_cur;
        case (phase_cur)
            PH_SILENT:  phase_next = PH_SILENT;
            PH_ATTACK:  phase_next = done ? PH_DECAY   : PH_ATTACK;
            PH_DECAY:   phase_next = done ? PH_SUSTAIN : PH_DECAY;
            PH_SUSTAIN: phase_next = done ? PH_RELEASE : PH_SUSTAIN;
            PH_RELEASE: phase_next = done ? PH_SILENT  : PH_RELEASE;
            default:    phase_next = PH_SILENT;
        endcase
    end

    // position, gain and key history
    always_comb
    begin
        key_was_next = key;
        gain_next    = gain_used;
        if (phase_cur == PH_SILENT)
            pos_next = pos_cur;
        else if (done)
            pos_next = '0;
        else
            pos_next = pos_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SILENT;
            pos_reg     <= '0;
            gain_reg    <= '0;
            key_was_reg <= 1'b0;
        end
        else if (advance && cfg.enable)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            gain_reg    <= gain_next;
            key_was_reg <= key_was_next;
        end
    end

    // disabled: unity gain and frozen phase
    assign result.gain  = cfg.enable ? gain_used : GAIN_ONE;
    assign result.phase = cfg.enable ? phase_next : phase_reg;

endmodule

>>> hdl/adsr_envelope_gain.sv
// ----------------------------------------------------------------------------
// adsr_envelope_gain
// Linear ADSR envelope applied as a Q1.23 gain to a stream of audio samples.
// ----------------------------------------------------------------------------
// path: an accepted input item waits in the input register, then moves to the
//   result register, which drives m_tdata and holds while m_tready is low
// throughput: 1 item per cycle unless m_tready stalls, set by the single envelope
//   update and one sample-by-gain multiply between the input and result registers
// reset: asynchronous active low; envelope silent, gain 0, registers at defaults
// ----------------------------------------------------------------------------
module adsr_envelope_gain
    import adsr_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    localparam int IN_BITS    = ((SAMPLE_BITS + 1 + 7) / 8) * 8,
    localparam int OUT_BITS   = ((SAMPLE_BITS + GAIN_BITS + PHASE_BITS + 7) / 8) * 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_BITS-1:0]        s_tdata,   // sample_in, key_held

    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_BITS-1:0]       m_tdata,   // sample_out, gain_level, phase_code

    // register writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;

    adsr_cfg_t cfg_reg;

    // input register
    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;
    logic                          in_key_reg;

    // result register
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic [GAIN_BITS-1:0]          out_gain_reg;
    phase_t                        out_phase_reg;

    logic                          advance;
    env_result_t                   env;
    logic signed [SAMPLE_BITS-1:0] sample_ext;
    logic signed [GAIN_BITS:0]     gain_ext;
    logic signed [PROD_BITS-1:0]   prod;

    // ---------------------------------------------------------------- config
    // writes must land only while the stream is idle; the block does not enforce it, and writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable          <= 1'b0;
            cfg_reg.attack_samples  <= 16'd50;
            cfg_reg.decay_samples   <= 16'd50;
            cfg_reg.sustain_samples <= 16'd100;
            cfg_reg.release_samples <= 16'd50;
            cfg_reg.attack_step     <= 25'sd167772;
            cfg_reg.decay_step      <= -25'sd50332;
            cfg_reg.release_step    <= -25'sd117441;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ENABLE:          cfg_reg.enable          <= cfg_data[0];
                REG_ATTACK_SAMPLES:  cfg_reg.attack_samples  <= cfg_data[LEN_BITS-1:0];
                REG_DECAY_SAMPLES:   cfg_reg.decay_samples   <= cfg_data[LEN_BITS-1:0];
                REG_SUSTAIN_SAMPLES: cfg_reg.sustain_samples <= cfg_data[LEN_BITS-1:0];
                REG_RELEASE_SAMPLES: cfg_reg.release_samples <= cfg_data[LEN_BITS-1:0];
                REG_ATTACK_STEP:     cfg_reg.attack_step     <= $signed(cfg_data);
                REG_DECAY_STEP:      cfg_reg.decay_step      <= $signed(cfg_data);
                REG_RELEASE_STEP:    cfg_reg.release_step    <= $signed(cfg_data);
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // ------------------------------------------------------------- handshake
    // an item moves from the input register to the result register whenever
    // the result register is empty or is being drained in the same cycle
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_sample_reg <= $signed(s_tdata[SAMPLE_BITS-1:0]);
            in_key_reg    <= s_tdata[SAMPLE_BITS];
        end
    end

    // ------------------------------------------------------------- envelope
    // state steps once per item that advances; disabled freezes it and
    // reports unity gain, so the multiply below passes the sample through
    adsr_env_state #(
        .COUNT_BITS (COUNT_BITS)
    ) u_env_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .advance (advance),
        .key     (in_key_reg),
        .result  (env)
    );

    // ---------------------------------------------------------------- scale
    // gain is at most 1.0, so the shifted product always fits the sample width;
    // arithmetic shift right gives floor rounding for negative products
    assign sample_ext = in_sample_reg;
    assign gain_ext   = $signed({1'b0, env.gain});
    assign prod       = PROD_BITS'(sample_ext * gain_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_sample_reg <= prod[SAMPLE_BITS+GAIN_SHIFT-1:GAIN_SHIFT];
            out_gain_reg   <= env.gain;
            out_phase_reg  <= env.phase;
        end
    end

    // result packing, lowest field first
    always_comb
    begin
        m_tdata = '0;
        m_tdata[SAMPLE_BITS-1:0]                     = out_sample_reg;
        m_tdata[SAMPLE_BITS+GAIN_BITS-1:SAMPLE_BITS] = out_gain_reg;
        m_tdata[SAMPLE_BITS+GAIN_BITS+PHASE_BITS-1:SAMPLE_BITS+GAIN_BITS] = out_phase_reg;
    end

endmodule

>>> hdl/adsr_checker.sv
// ----------------------------------------------------------------------------
// adsr_checker
// Port-level checks for the ADSR envelope gain block, bound to the top level.
// ----------------------------------------------------------------------------
module adsr_checker
    import adsr_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int OUT_BITS    = ((SAMPLE_BITS + GAIN_BITS + PHASE_BITS + 7) / 8) * 8
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OUT_BITS-1:0] m_tdata
);

    logic [SAMPLE_BITS-1:0] sample_out;
    logic [GAIN_BITS-1:0]   gain_level;

    assign sample_out = m_tdata[SAMPLE_BITS-1:0];
    assign gain_level = m_tdata[SAMPLE_BITS+GAIN_BITS-1:SAMPLE_BITS];

    // a stalled item holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // input side only stalls behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a waiting result");

    // gain never exceeds unity
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> gain_level <= GAIN_ONE)
        else $error("gain above 1.0");

    // zero gain mutes the sample
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (gain_level == '0) |-> sample_out == '0)
        else $error("nonzero sample at zero gain");

endmodule

bind adsr_envelope_gain adsr_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_adsr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
